@@ hw/rtl/rpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg: shared types, constants and CRC helpers
// Byte positions of a packet burst, the registered item layout and the
// CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam logic [7:0]  SYNC_MARK    = 8'hFF;
  localparam logic [7:0]  VERSION_MARK = 8'hFE;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'h0000;

  localparam logic [15:0] WIRE_EXTRA = 16'd4;
  localparam logic [15:0] SUB_EXTRA  = 16'd2;

  // Item kinds carried on tuser
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam logic REG_FLAGS = 1'b0;

  // Position of the byte being driven within a burst
  typedef logic [3:0] pos_t;

  localparam pos_t POS_SYNC    = 4'd0;
  localparam pos_t POS_VERSION = 4'd1;
  localparam pos_t POS_FLAGS   = 4'd2;
  localparam pos_t POS_WIRE_LO = 4'd3;
  localparam pos_t POS_WIRE_HI = 4'd4;
  localparam pos_t POS_SUB_LO  = 4'd5;
  localparam pos_t POS_SUB_HI  = 4'd6;
  localparam pos_t POS_BOARD   = 4'd7;
  localparam pos_t POS_FUNC    = 4'd8;
  localparam pos_t POS_PAYLOAD = 4'd9;
  localparam pos_t POS_CRC_LO  = 4'd10;
  localparam pos_t POS_CRC_HI  = 4'd11;

  typedef struct packed {
    logic        mode;
    logic [7:0]  board;
    logic [7:0]  func;
    logic [15:0] payload_count;
    logic [7:0]  data_byte;
  } item_t;

  // Remainder of one table entry: eight shift/xor steps
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

@@ hw/rtl/rpf_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_in_reg: input register
// Holds one accepted item until the burst emitter takes it.
// ----------------------------------------------------------------------------
module rpf_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [39:0]    s_tdata,  // board, func, payload_count, data_byte
  input  logic           s_tuser,  // mode
  output logic           item_vld,
  output rpf_pkg::item_t item,
  input  logic           item_take
);

  logic vld;

  assign s_tready = !vld || item_take;
  assign item_vld = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  // Payload register: load on every accepted item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode          <= s_tuser;
      item.board         <= s_tdata[7:0];
      item.func          <= s_tdata[15:8];
      item.payload_count <= s_tdata[31:16];
      item.data_byte     <= s_tdata[39:32];
    end
  end

endmodule

@@ hw/rtl/rpf_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_emitter: packet state and byte burst sequencer
// Turns each item into its burst of wire bytes and folds covered bytes into
// the running CRC as they leave.
// ----------------------------------------------------------------------------
module rpf_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     flags_byte,
  input  logic           item_vld,
  input  rpf_pkg::item_t item,
  output logic           item_take,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,  // out_byte
  output logic           m_tlast   // is_last
);

  logic          busy;
  rpf_pkg::pos_t pos;
  rpf_pkg::pos_t end_pos;
  logic [15:0]   crc;
  logic [15:0]   bytes_left;
  logic          in_packet;

  logic [7:0]    board;
  logic [7:0]    func;
  logic [15:0]   wire_len;
  logic [15:0]   sub_len;
  logic [7:0]    data;

  logic          beat;
  logic          last_beat;
  logic          load_start;
  logic          load_pay;
  logic [15:0]   bytes_left_next;
  logic [7:0]    out_byte;

  assign beat      = busy && m_tready;
  assign last_beat = beat && (pos == end_pos);
  assign item_take = item_vld && (!busy || last_beat);

  // Stray payload items are taken with no burst
  assign load_start = item_take && (item.mode == rpf_pkg::MODE_START);
  assign load_pay   = item_take && (item.mode == rpf_pkg::MODE_PAYLOAD) && in_packet;

  assign bytes_left_next = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;

  always_comb begin
    case (pos)
      rpf_pkg::POS_SYNC:    out_byte = rpf_pkg::SYNC_MARK;
      rpf_pkg::POS_VERSION: out_byte = rpf_pkg::VERSION_MARK;
      rpf_pkg::POS_FLAGS:   out_byte = flags_byte;
      rpf_pkg::POS_WIRE_LO: out_byte = wire_len[7:0];
      rpf_pkg::POS_WIRE_HI: out_byte = wire_len[15:8];
      rpf_pkg::POS_SUB_LO:  out_byte = sub_len[7:0];
      rpf_pkg::POS_SUB_HI:  out_byte = sub_len[15:8];
      rpf_pkg::POS_BOARD:   out_byte = board;
      rpf_pkg::POS_FUNC:    out_byte = func;
      rpf_pkg::POS_PAYLOAD: out_byte = data;
      rpf_pkg::POS_CRC_LO:  out_byte = crc[7:0];
      rpf_pkg::POS_CRC_HI:  out_byte = crc[15:8];
      default:              out_byte = 8'h00;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = out_byte;
  assign m_tlast  = (pos == rpf_pkg::POS_CRC_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pos        <= rpf_pkg::POS_SYNC;
      end_pos    <= rpf_pkg::POS_SYNC;
      crc        <= rpf_pkg::CRC_INIT;
      bytes_left <= 16'd0;
      in_packet  <= 1'b0;
    end else if (load_start) begin
      // a new start drops any open packet
      busy       <= 1'b1;
      pos        <= rpf_pkg::POS_SYNC;
      end_pos    <= (item.payload_count == 16'd0) ? rpf_pkg::POS_CRC_HI
                                                  : rpf_pkg::POS_FUNC;
      crc        <= rpf_pkg::CRC_INIT;
      bytes_left <= item.payload_count;
      in_packet  <= (item.payload_count != 16'd0);
    end else begin
      // fold sub-length, board, function and payload bytes into the CRC
      if (beat && (pos inside {[rpf_pkg::POS_SUB_LO:rpf_pkg::POS_PAYLOAD]})) begin
        crc <= rpf_pkg::crc_feed(crc, out_byte);
      end
      if (load_pay) begin
        busy       <= 1'b1;
        pos        <= rpf_pkg::POS_PAYLOAD;
        end_pos    <= (bytes_left_next == 16'd0) ? rpf_pkg::POS_CRC_HI
                                                 : rpf_pkg::POS_PAYLOAD;
        bytes_left <= bytes_left_next;
        in_packet  <= (bytes_left_next != 16'd0);
      end else begin
        if (beat && (pos != end_pos)) begin
          // an empty packet skips the payload slot
          pos <= (pos == rpf_pkg::POS_FUNC) ? rpf_pkg::POS_CRC_LO : pos + 4'd1;
        end
        if (last_beat) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_start) begin
      board    <= item.board;
      func     <= item.func;
      wire_len <= item.payload_count + rpf_pkg::WIRE_EXTRA;
      sub_len  <= item.payload_count + rpf_pkg::SUB_EXTRA;
    end
    if (load_pay) begin
      data <= item.data_byte;
    end
  end

endmodule

@@ hw/rtl/rs485_packet_framer_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_packet_framer_crc16: bus packet framer with CRC-16/ARC
// An accepted item passes the input register, then the emitter state, before
// its first byte is offered. One output byte per cycle while m_tready is high; a
// payload item gives 1 byte, 3 if it closes the packet; a start item 9 or 11.
// Reset (rst, synchronous): no packet open, CRC and count cleared, flags 0.
// ----------------------------------------------------------------------------
module rs485_packet_framer_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // board, func, payload_count, data_byte
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte
  output logic        m_tlast,  // is_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           flags_byte;
  logic [7:0]     flags;
  logic           item_vld;
  rpf_pkg::item_t item;
  logic           item_take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= 8'h00;
    end else if (psel && penable && pwrite && pready && (paddr[2] == rpf_pkg::REG_FLAGS)) begin
      flags <= pwdata[7:0];
    end
  end

  assign flags_byte = (paddr[2] == rpf_pkg::REG_FLAGS);
  assign prdata     = flags_byte ? {24'h000000, flags} : 32'h00000000;

  rpf_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  rpf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .flags_byte (flags),
    .item_vld   (item_vld),
    .item       (item),
    .item_take  (item_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

@@ tb/sv/rs485_packet_framer_crc16_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_packet_framer_crc16_tb: self-checking bench for the packet framer
// Sends start and payload items into the stream input and predicts every
// header, payload and CRC-16/ARC byte. It compares the output stream byte by
// byte over several flags settings and idle/backpressure patterns.
// ----------------------------------------------------------------------------
module rs485_packet_framer_crc16_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 16;
  localparam int NUM_PHASES   = 5;
  localparam int NUM_ROWS     = 22;

  localparam logic [2:0] FLAGS_ADDR = 3'(4 * rpf_pkg::REG_FLAGS);

  localparam logic [7:0] PHASE_FLAGS [NUM_PHASES] = '{8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01};
  localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 82, 0, 29, 0};
  localparam int PHASE_STALL [NUM_PHASES]     = '{0, 0, 82, 29, 0};

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  board;
    logic [7:0]  func;
    logic [15:0] count;
    logic [7:0]  data;
    logic [3:0]  n_bytes;
  } frame_row_t;

  // Directed items; n_bytes is the number of wire bytes each one must cause
  localparam frame_row_t FRAME_ROWS [NUM_ROWS] = '{
    '{rpf_pkg::MODE_PAYLOAD, 8'h12, 8'h34, 16'h0005, 8'hFF, 4'd0},  // stray byte after reset
    '{rpf_pkg::MODE_START,   8'h00, 8'h00, 16'h0000, 8'hA5, 4'd11}, // empty packet
    '{rpf_pkg::MODE_START,   8'hFF, 8'hFF, 16'h0001, 8'h00, 4'd9},
    '{rpf_pkg::MODE_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 4'd3},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 4'd0},  // stray byte
    '{rpf_pkg::MODE_START,   8'h12, 8'h34, 16'h0003, 8'hC3, 4'd9},
    '{rpf_pkg::MODE_PAYLOAD, 8'hAB, 8'hCD, 16'h1234, 8'h00, 4'd1},
    '{rpf_pkg::MODE_START,   8'hA5, 8'h5A, 16'h0002, 8'h3C, 4'd9},  // abandons open packet
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h80, 4'd1},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h7F, 4'd3},
    '{rpf_pkg::MODE_START,   8'h01, 8'h02, 16'hFFFB, 8'h00, 4'd9},  // largest regular count
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h55, 4'd1},
    '{rpf_pkg::MODE_START,   8'h03, 8'h04, 16'hFFFF, 8'h00, 4'd9},  // lengths wrap
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hAA, 4'd1},
    '{rpf_pkg::MODE_START,   8'h05, 8'h06, 16'hFFFC, 8'h00, 4'd9},
    '{rpf_pkg::MODE_START,   8'h07, 8'h08, 16'h8000, 8'h00, 4'd9},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h01, 4'd1},
    '{rpf_pkg::MODE_START,   8'hFF, 8'h00, 16'h0000, 8'hFF, 4'd11},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 4'd0},
    '{rpf_pkg::MODE_START,   8'h00, 8'hFF, 16'h0002, 8'h00, 4'd9},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'hFF, 4'd1},
    '{rpf_pkg::MODE_PAYLOAD, 8'h00, 8'h00, 16'h0000, 8'h00, 4'd3}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [31:0] prdata;
  logic        pready;

  // Framer state as the bench sees it
  logic [7:0]  fr_flags;
  logic [15:0] fr_crc;
  logic [15:0] fr_left;
  logic        fr_open;

  wire_byte_t  wire_q[$];
  wire_byte_t  head_byte;
  int          errors = 0;
  int          framed_items;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  rs485_packet_framer_crc16 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {8'h00, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ rpf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Append one predicted wire byte
  function automatic void queue_byte(input logic [7:0] value, input logic last);
    wire_byte_t wb;
    wb.value = value;
    wb.last  = last;
    wire_q   = {wire_q, wb};
  endfunction

  task automatic close_packet(inout int n);
    queue_byte(fr_crc[7:0], 1'b0);
    queue_byte(fr_crc[15:8], 1'b1);
    fr_open = 1'b0;
    n += 2;
  endtask

  // Append the wire bytes one accepted item causes
  task automatic frame_item(input logic mode, input logic [7:0] board, input logic [7:0] func,
                            input logic [15:0] count, input logic [7:0] data, output int n);
    logic [15:0] wire_len;
    logic [15:0] sub_len;
    n = 0;
    if (mode == rpf_pkg::MODE_START) begin
      wire_len = count + rpf_pkg::WIRE_EXTRA;
      sub_len  = count + rpf_pkg::SUB_EXTRA;
      queue_byte(rpf_pkg::SYNC_MARK, 1'b0);
      queue_byte(rpf_pkg::VERSION_MARK, 1'b0);
      queue_byte(fr_flags, 1'b0);
      queue_byte(wire_len[7:0], 1'b0);
      queue_byte(wire_len[15:8], 1'b0);
      queue_byte(sub_len[7:0], 1'b0);
      queue_byte(sub_len[15:8], 1'b0);
      queue_byte(board, 1'b0);
      queue_byte(func, 1'b0);
      n = 9;
      fr_crc  = crc_arc_byte(rpf_pkg::CRC_INIT, sub_len[7:0]);
      fr_crc  = crc_arc_byte(fr_crc, sub_len[15:8]);
      fr_crc  = crc_arc_byte(fr_crc, board);
      fr_crc  = crc_arc_byte(fr_crc, func);
      fr_left = count;
      fr_open = 1'b1;
      if (fr_left == 0) close_packet(n);
    end else if (fr_open) begin
      queue_byte(data, 1'b0);
      n = 1;
      fr_crc = crc_arc_byte(fr_crc, data);
      if (fr_left != 0) fr_left--;
      if (fr_left == 0) close_packet(n);
    end
  endtask

  task automatic send_item(input logic mode, input logic [7:0] board, input logic [7:0] func,
                           input logic [15:0] count, input logic [7:0] data, output int n);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {data, count, func, board};
    do @(posedge clk); while (!s_tready);
    frame_item(mode, board, func, count, data, n);
    if (n != 0) framed_items++;
  endtask

  // Fill the board, function and data fields with random values
  task automatic random_item(input logic mode, input logic [15:0] count);
    int n;
    send_item(mode, 8'($urandom), 8'($urandom), count, 8'($urandom), n);
  endtask

  task automatic random_packet();
    int          r;
    int          pay;
    logic [15:0] cnt;
    r = $urandom_range(99);
    if (r < 8) begin
      random_item(rpf_pkg::MODE_PAYLOAD, 16'($urandom));
    end else if (r < 16) begin
      // huge count: leave the packet open for the next start to abandon
      cnt = 16'($urandom);
      random_item(rpf_pkg::MODE_START, cnt);
      repeat ($urandom_range(3)) random_item(rpf_pkg::MODE_PAYLOAD, 16'($urandom));
    end else begin
      cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6));
      pay = cnt;
      if (cnt != 0 && $urandom_range(9) == 0) pay = $urandom_range(cnt - 1);
      random_item(rpf_pkg::MODE_START, cnt);
      repeat (pay) random_item(rpf_pkg::MODE_PAYLOAD, 16'($urandom));
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the flags register, then read it back
  task automatic set_flags(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLAGS_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== {24'h0, value}) begin
      errors++;
      $error("flags_byte: expected %08h, got %08h", {24'h0, value}, prdata);
    end
    fr_flags = value;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (wire_q.size() == 0) begin
        errors++;
        $error("out_byte: nothing expected, got %02h (is_last %0b)", m_tdata, m_tlast);
      end else begin
        head_byte = wire_q.pop_front();
        if (m_tdata !== head_byte.value) begin
          errors++;
          $error("out_byte: expected %02h, got %02h", head_byte.value, m_tdata);
        end
        if (m_tlast !== head_byte.last) begin
          errors++;
          $error("is_last: expected %0b, got %0b", head_byte.last, m_tlast);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int         i;
    int         n;
    frame_row_t row;
    logic [7:0] flags_val;
    fr_flags = 8'h00;
    fr_crc   = rpf_pkg::CRC_INIT;
    fr_left  = 16'h0;
    fr_open  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_ROWS; i++) begin
      row = FRAME_ROWS[i];
      send_item(row.mode, row.board, row.func, row.count, row.data, n);
      if (n != row.n_bytes) begin
        errors++;
        $error("byte count: expected %0d, got %0d", row.n_bytes, n);
      end
    end

    for (i = 0; i < NUM_PHASES; i++) begin
      wait_idle();
      flags_val = (i == 2) ? 8'($urandom) : PHASE_FLAGS[i];
      set_flags(flags_val);
      send_idle_pct = PHASE_SEND_IDLE[i];
      stall_pct     = PHASE_STALL[i];
      framed_items  = 0;
      while (framed_items < PHASE_ITEMS) random_packet();
    end

    wait_idle();
    if (errors == 0 && wire_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
